FILE: src/source_comment_stripper_defines.svh
// Assertion macros used by the checker file of the comment stripper.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SOURCE_COMMENT_STRIPPER_DEFINES_SVH
`define SOURCE_COMMENT_STRIPPER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("comment stripper check failed");

// Next-cycle implication, checked outside reset.
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("comment stripper check failed");

`endif

FILE: src/scs_pkg.sv
// Shared types and constants of the comment stripper.
// No dependencies; scs_scan, the top level and the checker import it.
package scs_pkg;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Result queue: room for the two results one byte can produce, plus slack.
  localparam int QDEPTH = 4;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       last_out;
  } result_t;

  // Results produced by one accepted byte.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    e0;
    result_t    e1;
  } push_t;

endpackage

FILE: src/scs_if.sv
// Valid/ready channel interfaces for the comment stripper.
// Depends on nothing but the port widths fixed by the block.
interface scs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface scs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       has_char;
  logic       last_out;

  modport source (output valid, output char_out, output has_char, output last_out,
                  input ready);
  modport sink   (input valid, input char_out, input has_char, input last_out,
                  output ready);
endinterface

FILE: src/scs_scan.sv
// Scanner state and per-byte result logic of the comment stripper.
// Depends on scs_pkg for the character constants and the result types.
module scs_scan
  import scs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] char_in,
  input  logic       end_of_text,
  output push_t      push
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_SLASH  = 3'd1;
  localparam logic [2:0] MODE_LINE   = 3'd2;
  localparam logic [2:0] MODE_BLOCK  = 3'd3;
  localparam logic [2:0] MODE_STAR   = 3'd4;

  logic [2:0] mode_r;
  logic [2:0] mode_nxt;
  logic [2:0] mode_scan;
  logic [1:0] np;
  result_t    e0;
  result_t    e1;

  always_comb begin
    np        = 2'd0;
    e0        = '{char_out: char_in, has_char: 1'b1, last_out: 1'b0};
    e1        = '{char_out: char_in, has_char: 1'b1, last_out: 1'b0};
    mode_scan = mode_r;

    unique case (mode_r)
      MODE_SLASH: begin
        if (char_in == CH_SLASH) begin
          mode_scan = MODE_LINE;
        end else if (char_in == CH_STAR) begin
          mode_scan = MODE_BLOCK;
        end else begin
          // The held slash was not an opener: release it ahead of this byte.
          e0.char_out = CH_SLASH;
          np          = 2'd2;
          mode_scan   = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (char_in == CH_NEWLINE) mode_scan = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (char_in == CH_STAR) mode_scan = MODE_STAR;
      end
      MODE_STAR: begin
        if (char_in == CH_SLASH) begin
          mode_scan = MODE_NORMAL;
        end else if (char_in != CH_STAR) begin
          mode_scan = MODE_BLOCK;
        end
      end
      default: begin
        if (char_in == CH_SLASH) begin
          mode_scan = MODE_SLASH;
        end else begin
          np        = 2'd1;
          mode_scan = MODE_NORMAL;
        end
      end
    endcase

    mode_nxt = mode_scan;
    if (end_of_text) begin
      // A slash still pending at the end of the text is plain text.
      if (mode_scan == MODE_SLASH) begin
        e0.char_out = CH_SLASH;
        np          = 2'd1;
      end
      if (np == 2'd0) begin
        e0 = '{char_out: 8'h00, has_char: 1'b0, last_out: 1'b0};
        np = 2'd1;
      end
      if (np == 2'd2) begin
        e1.last_out = 1'b1;
      end else begin
        e0.last_out = 1'b1;
      end
      mode_nxt = MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
    end
  end

  assign push.cnt = in_fire ? np : 2'd0;
  assign push.e0  = e0;
  assign push.e1  = e1;

endmodule

FILE: src/source_comment_stripper.sv
// Top level of the C/C++ comment stripper: scanner plus result queue.
// Depends on scs_pkg, scs_if.sv and scs_scan.
//
// Usage:
//   in_ch takes one byte of source text per transfer, with end_of_text set
//   on the final byte of a text. out_ch gives the kept bytes in order, one
//   per transfer; the final result of a text has last_out set, and a result
//   with has_char clear is a bare end marker carrying no byte.
//   Each result is written into the queue register when the byte that
//   caused it is transferred in, and is offered on out_ch from the queue head.
//   Throughput: one input byte per cycle while in_ch.ready is high. A byte
//   yields zero, one or two results; the output drains one result per cycle
//   while out_ch.ready is high, through a four-entry queue, so a byte that
//   releases a held slash leaves a second result to drain. in_ch.ready is
//   high whenever the queue has room for two results, and does not depend
//   on out_ch.ready. Reset empties the queue and returns the scanner to
//   plain text with no pending slash. When the receiver stalls, the head
//   result holds steady and input is taken until the queue is nearly full.
module source_comment_stripper
  import scs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  scs_in_if.sink    in_ch,
  scs_out_if.source out_ch
);

  push_t            push;
  result_t          q_r [QDEPTH];
  result_t          q_nxt [QDEPTH];
  result_t          shifted [QDEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] base;
  logic             in_fire;
  logic             pop;

  assign in_ch.ready = (cnt_r <= CNT_W'(QDEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (cnt_r != '0);
  assign pop          = out_ch.valid && out_ch.ready;

  scs_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .char_in     (in_ch.char_in),
    .end_of_text (in_ch.end_of_text),
    .push        (push)
  );

  always_comb begin
    for (int i = 0; i < QDEPTH - 1; i++) begin
      shifted[i] = pop ? q_r[i + 1] : q_r[i];
    end
    shifted[QDEPTH - 1] = q_r[QDEPTH - 1];
  end

  assign base    = cnt_r - CNT_W'(pop);
  assign cnt_nxt = base + CNT_W'(push.cnt);

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = shifted[i];
      if (push.cnt != 2'd0 && base == CNT_W'(i)) begin
        q_nxt[i] = push.e0;
      end
      if (push.cnt == 2'd2 && base + CNT_W'(1) == CNT_W'(i)) begin
        q_nxt[i] = push.e1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_ch.char_out = q_r[0].char_out;
  assign out_ch.has_char = q_r[0].has_char;
  assign out_ch.last_out = q_r[0].last_out;

endmodule

FILE: src/scs_checker.sv
// Port-level checks of the comment stripper, bound to the top level.
// Depends on source_comment_stripper_defines.svh and scs_pkg.
`include "source_comment_stripper_defines.svh"

module scs_checker
  import scs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] char_out,
  input logic       has_char,
  input logic       last_out
);

  logic slash_fire;

  // A slash that is not the end of a text is only released together with
  // the byte that follows it, so that byte must already be waiting.
  assign slash_fire = out_valid && out_ready && has_char && !last_out &&
                      (char_out == CH_SLASH);

  `SCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(char_out) && $stable(has_char) && $stable(last_out))
  `SCS_ASSERT_NOW(a_bare_is_last, out_valid && !has_char,
    last_out && (char_out == 8'h00))
  `SCS_ASSERT_NEXT(a_slash_follower, slash_fire,
    out_valid && has_char && (char_out != CH_SLASH) && (char_out != CH_STAR))

endmodule

bind source_comment_stripper scs_checker u_scs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .char_out  (out_ch.char_out),
  .has_char  (out_ch.has_char),
  .last_out  (out_ch.last_out)
);
